[rtl/core/assert_macros.svh]
// Assertion macros used by the top level of the sorted priority queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising edge of clk, held off while arst_n is low.
`define SPQ_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Concurrent assertion that an expression is never true.
`define SPQ_ASSERT_NEVER(name, expr, msg) \
	`SPQ_ASSERT(name, !(expr), msg)

`endif

[rtl/core/srtpq_pkg.sv]
// Package with the codes and control types of the sorted priority queue.
package srtpq_pkg;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic execute;
	} srtpq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
	} srtpq_sts_t;

endpackage

[rtl/core/srtpq_ctrl.sv]
// Controller state machine of the sorted priority queue.
module srtpq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  srtpq_pkg::srtpq_sts_t sts,
	output srtpq_pkg::srtpq_cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;

	assign in_ready    = (state_q == ST_IDLE);
	assign cmd.capture = in_ready && in_valid;
	assign cmd.execute = (state_q == ST_EXEC) && sts.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.capture) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (cmd.execute) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/core/srtpq_dp.sv]
// Datapath of the sorted priority queue: sorted entry array, command and result registers.
module srtpq_dp #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32,
	parameter int PRIO_WIDTH = 8,
	parameter int CW         = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  srtpq_pkg::srtpq_cmd_t cmd,
	output srtpq_pkg::srtpq_sts_t sts,
	input  logic [1:0]            in_op,
	input  logic [DATA_WIDTH-1:0] in_data,
	input  logic [PRIO_WIDTH-1:0] in_prio,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [DATA_WIDTH-1:0] out_data,
	output logic                  out_removed,
	output logic [1:0]            out_status,
	output logic [CW-1:0]         out_count
);

	logic [1:0]            op_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic [PRIO_WIDTH-1:0] prio_q;

	logic [DATA_WIDTH-1:0] ent_data_q [DEPTH];
	logic [PRIO_WIDTH-1:0] ent_prio_q [DEPTH];
	logic [CW-1:0]         count_q;

	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] out_data_q;
	logic                  out_removed_q;
	logic [1:0]            out_status_q;

	logic [DEPTH-1:0] gt;
	logic [DEPTH-1:0] shift_in;
	logic [DEPTH-1:0] take_new;
	logic             full;
	logic             empty;
	logic             do_insert;
	logic             do_remove;

	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign do_insert = cmd.execute && (op_q == srtpq_pkg::OP_INSERT) && !full;
	assign do_remove = cmd.execute && (op_q == srtpq_pkg::OP_REMOVE) && !empty;

	assign sts.out_free = !out_valid_q || out_ready;

	// Held entries above the new priority move back one place; the new entry lands
	// at the first of them, or at the tail when none is larger.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			gt[i] = (CW'(i) < count_q) && (ent_prio_q[i] > prio_q);
		end
		shift_in[0] = 1'b0;
		for (int i = 1; i < DEPTH; i++) begin
			shift_in[i] = gt[i-1];
		end
		for (int i = 0; i < DEPTH; i++) begin
			take_new[i] = !shift_in[i] && (gt[i] || (count_q == CW'(i)));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= in_op;
			data_q <= in_data;
			prio_q <= in_prio;
		end
	end

	always_ff @(posedge clk) begin
		if (do_insert) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (take_new[i]) begin
					ent_data_q[i] <= data_q;
					ent_prio_q[i] <= prio_q;
				end
			end
			for (int i = 1; i < DEPTH; i++) begin
				if (shift_in[i]) begin
					ent_data_q[i] <= ent_data_q[i-1];
					ent_prio_q[i] <= ent_prio_q[i-1];
				end
			end
		end else if (do_remove) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				ent_data_q[i] <= ent_data_q[i+1];
				ent_prio_q[i] <= ent_prio_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_insert) begin
				count_q <= count_q + CW'(1);
			end else if (do_remove) begin
				count_q <= count_q - CW'(1);
			end else if (cmd.execute && (op_q == srtpq_pkg::OP_CLEAR)) begin
				count_q <= '0;
			end
			if (cmd.execute) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			out_data_q    <= do_remove ? ent_data_q[0] : '0;
			out_removed_q <= do_remove;
			if ((op_q == srtpq_pkg::OP_INSERT) && full) begin
				out_status_q <= srtpq_pkg::ST_FULL;
			end else if ((op_q == srtpq_pkg::OP_REMOVE) && empty) begin
				out_status_q <= srtpq_pkg::ST_EMPTY;
			end else begin
				out_status_q <= srtpq_pkg::ST_OK;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_data    = out_data_q;
	assign out_removed = out_removed_q;
	assign out_status  = out_status_q;
	assign out_count   = count_q;

endmodule

[rtl/core/sorted_priority_queue.sv]
// Top level of the sorted priority queue: controller, datapath and stream ports.
//
// The queue holds up to DEPTH entries sorted by priority, lowest value first, and
// first in, first out among equal priorities. Each slave-side transaction carries one
// operation in s_axis_tuser (insert, remove front entry, clear) with the payload and
// priority in s_axis_tdata. Every operation yields exactly one master-side transaction
// that carries the removed payload (zero when nothing was removed) and the entry count
// after the operation in m_axis_tdata, and the removed flag and a status code in
// m_axis_tuser.
// An operation is accepted into the command register and then applied to the entry
// array, so no new one is taken until the last one is applied; the output register
// takes the result as the operation is applied. Insert and remove act on all
// entries at once, with one priority compare per slot and a one-place shift.
// The output register decouples the two sides: a new operation is accepted while an
// earlier result still waits, and it is applied as soon as that result is taken. While
// m_axis_tready stays low, the block holds its result and accepts at most one more
// operation. Reset empties the queue and drops any pending result; stored entries are
// not cleared, since only entries below the count are ever read.
module sorted_priority_queue #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32,
	parameter int PRIO_WIDTH = 8
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                                            s_axis_tvalid,
	output logic                                            s_axis_tready,
	// Fields from bit 0 up: data, priority_req.
	input  logic [((DATA_WIDTH+PRIO_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
	// Fields from bit 0 up: op.
	input  logic [1:0]                                      s_axis_tuser,

	output logic                                            m_axis_tvalid,
	input  logic                                            m_axis_tready,
	// Fields from bit 0 up: removed_data, count.
	output logic [((DATA_WIDTH+$clog2(DEPTH+1)+7)/8)*8-1:0] m_axis_tdata,
	// Fields from bit 0 up: removed_valid, status.
	output logic [2:0]                                      m_axis_tuser
);

	`include "assert_macros.svh"

	localparam int CW      = $clog2(DEPTH + 1);
	localparam int OUT_TDW = ((DATA_WIDTH + CW + 7) / 8) * 8;

	srtpq_pkg::srtpq_cmd_t cmd;
	srtpq_pkg::srtpq_sts_t sts;

	logic [DATA_WIDTH-1:0] out_data;
	logic                  out_removed;
	logic [1:0]            out_status;
	logic [CW-1:0]         out_count;

	srtpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	srtpq_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.PRIO_WIDTH (PRIO_WIDTH),
		.CW         (CW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_op       (s_axis_tuser),
		.in_data     (s_axis_tdata[DATA_WIDTH-1:0]),
		.in_prio     (s_axis_tdata[DATA_WIDTH+PRIO_WIDTH-1:DATA_WIDTH]),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.out_data    (out_data),
		.out_removed (out_removed),
		.out_status  (out_status),
		.out_count   (out_count)
	);

	// The count sits directly above the payload; the rest of the word is zero.
	assign m_axis_tdata = OUT_TDW'({out_count, out_data});
	assign m_axis_tuser = {out_status, out_removed};

	// The reported count never goes past the queue depth.
	`SPQ_ASSERT(a_count_bound, m_axis_tvalid |-> (out_count <= CW'(DEPTH)), "count exceeds depth")
	// A removed entry always comes with an ok status.
	`SPQ_ASSERT(a_removed_ok, (m_axis_tvalid && out_removed) |-> (out_status == srtpq_pkg::ST_OK), "removed entry with error status")
	// An operation is never accepted in the cycle in which one is applied.
	`SPQ_ASSERT_NEVER(a_cap_exec, cmd.capture && cmd.execute, "capture and execute together")
	// After an acceptance the slave side closes until that operation is applied.
	`SPQ_ASSERT(a_one_pending, cmd.capture |=> !s_axis_tready, "second operation accepted while one is pending")

endmodule

[test/testbench.sv]
// Self-checking stream testbench for the sorted priority queue.
module testbench;
	import srtpq_pkg::*;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int PRIO_WIDTH = 8;
	localparam int CNT_WIDTH  = $clog2(DEPTH + 1);
	localparam int S_WIDTH    = ((DATA_WIDTH + PRIO_WIDTH + 7) / 8) * 8;
	localparam int M_WIDTH    = ((DATA_WIDTH + CNT_WIDTH + 7) / 8) * 8;

	// The op field is two bits wide; its fourth code does nothing.
	localparam logic [1:0] OP_NOP = 2'd3;

	localparam int RANDOM_ITEMS = 1075;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 200;

	typedef struct {
		logic [DATA_WIDTH-1:0] data;
		logic [PRIO_WIDTH-1:0] prio;
	} queue_entry_t;

	typedef struct {
		logic [DATA_WIDTH-1:0] data;
		logic                  valid;
		logic [1:0]            status;
		logic [CNT_WIDTH-1:0]  count;
	} queue_result_t;

	typedef struct {
		logic [1:0]            op;
		logic [DATA_WIDTH-1:0] data;
		logic [PRIO_WIDTH-1:0] prio;
		bit                    typed;
		queue_result_t         want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [S_WIDTH-1:0] s_axis_tdata;
	logic [1:0]         s_axis_tuser;
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [M_WIDTH-1:0] m_axis_tdata;
	logic [2:0]         m_axis_tuser;

	queue_entry_t  model_entries[$];
	queue_result_t pending_results[$];
	stim_row_t     directed_rows[$];
	int            mismatch_count = 0;
	int            cycle_count = 0;
	bit            hold_request = 1'b0;
	int            burst_left = 0;

	sorted_priority_queue #(
		.DEPTH(DEPTH),
		.DATA_WIDTH(DATA_WIDTH),
		.PRIO_WIDTH(PRIO_WIDTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Applies one operation to the shadow queue and returns the result it yields.
	// A new entry goes after every held entry of lower or equal priority.
	function automatic queue_result_t apply_queue_op(logic [1:0] op,
			logic [DATA_WIDTH-1:0] d, logic [PRIO_WIDTH-1:0] p);
		queue_result_t r;
		queue_entry_t  e;
		int            pos;
		r.data = '0;
		r.valid = 1'b0;
		r.status = ST_OK;
		case (op)
			OP_INSERT: begin
				if (model_entries.size() >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					pos = model_entries.size();
					while (pos > 0 && model_entries[pos-1].prio > p)
						pos--;
					e.data = d;
					e.prio = p;
					model_entries.insert(pos, e);
				end
			end
			OP_REMOVE: begin
				if (model_entries.size() == 0) begin
					r.status = ST_EMPTY;
				end else begin
					e = model_entries.pop_front();
					r.data = e.data;
					r.valid = 1'b1;
				end
			end
			OP_CLEAR: model_entries.delete();
			default: ;
		endcase
		r.count = CNT_WIDTH'(model_entries.size());
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		mismatch_count++;
		$display("mismatch at cycle %0d: %s got 0x%0h, expected 0x%0h",
			cycle_count, field, got, want);
	endtask

	task automatic add_row(logic [1:0] op, logic [DATA_WIDTH-1:0] d,
			logic [PRIO_WIDTH-1:0] p, bit typed = 1'b0, logic [1:0] status = ST_OK,
			int count = 0);
		stim_row_t row;
		row.op = op;
		row.data = d;
		row.prio = p;
		row.typed = typed;
		row.want.data = '0;
		row.want.valid = 1'b0;
		row.want.status = status;
		row.want.count = CNT_WIDTH'(count);
		directed_rows.push_back(row);
	endtask

	// Offers one transaction from a falling edge and returns at the falling edge
	// after it was accepted. The expectation is recorded at the accepting edge.
	task automatic send_item(logic [1:0] op, logic [DATA_WIDTH-1:0] d,
			logic [PRIO_WIDTH-1:0] p, bit typed, queue_result_t want);
		queue_result_t r;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {p, d};
		s_axis_tuser <= op;
		do
			@(posedge clk);
		while (!s_axis_tready);
		r = apply_queue_op(op, d, p);
		pending_results.push_back(typed ? want : r);
		@(negedge clk);
	endtask

	// Sender idling: long quiet stretches now and then, mostly short gaps, and
	// none at all while a burst is running against a stalled receiver.
	task automatic sender_gap();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else if ($urandom_range(0, 19) == 0) begin
			gap = $urandom_range(10, 40);
		end else if ($urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 3);
		end else begin
			gap = 0;
		end
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Receiver: segments of constant tready, with a long hold-off on request.
	initial begin
		int len;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_axis_tready <= 1'b0;
				len = HOLD_CYCLES;
			end else if ($urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b1;
				len = $urandom_range(30, 150);
			end else if ($urandom_range(0, 15) == 0) begin
				m_axis_tready <= 1'b0;
				len = $urandom_range(10, 40);
			end else begin
				m_axis_tready <= ($urandom_range(0, 2) != 0);
				len = $urandom_range(1, 3);
			end
			repeat (len - 1) @(negedge clk);
		end
	end

	// Result checker: every accepted result against the oldest expectation.
	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 64'(m_axis_tdata[DATA_WIDTH-1:0]),
					64'(0));
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tdata[DATA_WIDTH-1:0] !== want.data)
					report_mismatch("removed_data", 64'(m_axis_tdata[DATA_WIDTH-1:0]),
						64'(want.data));
				if (m_axis_tdata[DATA_WIDTH +: CNT_WIDTH] !== want.count)
					report_mismatch("count", 64'(m_axis_tdata[DATA_WIDTH +: CNT_WIDTH]),
						64'(want.count));
				if (m_axis_tuser[0] !== want.valid)
					report_mismatch("removed_valid", 64'(m_axis_tuser[0]), 64'(want.valid));
				if (m_axis_tuser[2:1] !== want.status)
					report_mismatch("status", 64'(m_axis_tuser[2:1]), 64'(want.status));
			end
		end
	end

	initial begin
		int             mode;
		int             roll;
		logic [1:0]     op;
		logic [PRIO_WIDTH-1:0] p;
		queue_result_t  no_want;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_NOP;
		no_want = '{default: '0};

		// Directed part: empty-queue corner cases, extremes of the fields, equal
		// priorities, filling the queue up to an overflowing insert, and a clear
		// of a populated queue.
		add_row(OP_REMOVE, '0, '0, 1'b1, ST_EMPTY, 0);
		add_row(OP_CLEAR, '0, '0, 1'b1, ST_OK, 0);
		add_row(OP_NOP, '1, '1, 1'b1, ST_OK, 0);
		add_row(OP_INSERT, '1, '1, 1'b1, ST_OK, 1);
		add_row(OP_INSERT, '0, '0, 1'b1, ST_OK, 2);
		add_row(OP_INSERT, 32'h0000_0005, '1, 1'b1, ST_OK, 3);
		add_row(OP_REMOVE, '0, '0);
		add_row(OP_INSERT, 32'hAAAA_AAAA, 8'h55);
		add_row(OP_INSERT, 32'h5555_5555, 8'hAA);
		for (int i = 0; i < 12; i++)
			add_row(OP_INSERT, 32'h1000_0000 + i, 8'(i * 23));
		add_row(OP_INSERT, 32'hDEAD_BEEF, 8'h01, 1'b1, ST_FULL, DEPTH);
		add_row(OP_REMOVE, '0, '0);
		add_row(OP_CLEAR, '0, '0, 1'b1, ST_OK, 0);
		add_row(OP_REMOVE, '1, '1, 1'b1, ST_EMPTY, 0);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			send_item(directed_rows[i].op, directed_rows[i].data, directed_rows[i].prio,
				directed_rows[i].typed, directed_rows[i].want);
			sender_gap();
		end

		// Random part: blocks that lean toward filling, draining or a balanced mix,
		// with priorities drawn from a narrow band (many ties) or the full range.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 64 == 0)
				mode = $urandom_range(0, 5);
			if (n == 150 || n == 650) begin
				hold_request = 1'b1;
				burst_left = 30;
			end
			roll = $urandom_range(0, 99);
			if (roll < 2)
				op = OP_CLEAR;
			else if (roll < 4)
				op = OP_NOP;
			else if (mode <= 1)
				op = (roll < 80) ? OP_INSERT : OP_REMOVE;
			else if (mode == 2)
				op = (roll < 25) ? OP_INSERT : OP_REMOVE;
			else
				op = (roll < 52) ? OP_INSERT : OP_REMOVE;
			if (mode % 2 == 0)
				p = PRIO_WIDTH'($urandom_range(0, 3)) | (($urandom_range(0, 1)) ? 8'hFC : 8'h00);
			else
				p = PRIO_WIDTH'($urandom);
			send_item(op, DATA_WIDTH'($urandom), p, 1'b0, no_want);
			sender_gap();
		end
		s_axis_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
